// File: rtl/battery_status_frame_generator_defines.svh
// Assertion macros for the battery status frame generator.
// Included by the modules that check their own logic; expects clk and rst_n in scope.
`ifndef BATTERY_STATUS_FRAME_GENERATOR_DEFINES_SVH
`define BATTERY_STATUS_FRAME_GENERATOR_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define BSFG_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define BSFG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/bsfg_pkg.sv
// Shared types and constants for the battery status frame generator.
// No dependencies; imported by every module of the block.
package bsfg_pkg;

  localparam int BODY_LEN = 11;  // bytes before the checksum
  localparam int FRAME_LEN = 12;

  typedef logic [7:0] byte_t;
  typedef logic [3:0] byte_idx_t;
  typedef logic [9:0] deci_t;

  typedef struct packed {
    logic [BODY_LEN-1:0][7:0] body;  // body[0] goes out first
  } frame_t;

  typedef enum logic [2:0] {
    REG_CELL_V_MAX_REGEN  = 3'd0,
    REG_CELL_V_MIN_ASSIST = 3'd1,
    REG_SOC_MAX_PERCENT   = 3'd2,
    REG_SOC_MIN_PERCENT   = 3'd3,
    REG_REDUCE_REGEN_MODE = 3'd4
  } cfg_reg_t;

  localparam logic ACTION_SEND   = 1'b0;
  localparam logic ACTION_RESYNC = 1'b1;

  localparam byte_idx_t LAST_IDX = byte_idx_t'(FRAME_LEN - 1);

  localparam byte_t FRAME_TYPE_87 = 8'h87;
  localparam byte_t FRAME_TYPE_AA = 8'hAA;
  localparam byte_t HDR_87        = 8'h40;
  localparam byte_t HDR_AA        = 8'h10;
  localparam byte_t FILL_87       = 8'h32;
  localparam byte_t FILL_AA       = 8'h61;
  localparam byte_t SOC_HI_MARK   = 8'h10;
  localparam byte_t FLAG_EMPTY    = 8'h10;
  localparam byte_t FLAG_FULL     = 8'h20;
  localparam byte_t REQ_BASE      = 8'h12;
  localparam byte_t REQ_EMPTY     = 8'h20;
  localparam byte_t REQ_FULL      = 8'h40;
  localparam byte_t B4_IDLE_A     = 8'd0;
  localparam byte_t B4_IDLE_B     = 8'd24;

  localparam deci_t SOC_TGT_FULL  = 10'd820;
  localparam deci_t SOC_TGT_EMPTY = 10'd200;
  localparam deci_t LIFT_LEVEL    = 10'd720;
  localparam deci_t LIFT_FLOOR    = 10'd250;

  localparam logic [13:0] CUR_OFFSET = 14'd2048;
  localparam logic signed [8:0] TEMP_OFFSET = 9'sd30;
  localparam logic signed [8:0] TEMP_MIN    = 9'sd51;

  localparam logic [15:0] RST_CELL_V_MAX = 16'd42000;
  localparam logic [15:0] RST_CELL_V_MIN = 16'd30000;
  localparam logic [6:0]  RST_SOC_MAX    = 7'd85;
  localparam logic [6:0]  RST_SOC_MIN    = 7'd10;

  localparam deci_t SOC_MAP [0:100] = '{
    10'd0,   10'd22,  10'd44,  10'd67,  10'd89,  10'd111, 10'd133, 10'd156, 10'd178, 10'd190,
    10'd200, 10'd209, 10'd217, 10'd225, 10'd232, 10'd240, 10'd248, 10'd256, 10'd264, 10'd272,
    10'd279, 10'd287, 10'd295, 10'd303, 10'd311, 10'd319, 10'd326, 10'd334, 10'd342, 10'd350,
    10'd355, 10'd363, 10'd375, 10'd387, 10'd399, 10'd411, 10'd423, 10'd435, 10'd447, 10'd459,
    10'd471, 10'd483, 10'd495, 10'd507, 10'd519, 10'd532, 10'd544, 10'd556, 10'd568, 10'd580,
    10'd592, 10'd604, 10'd616, 10'd628, 10'd640, 10'd652, 10'd664, 10'd676, 10'd688, 10'd700,
    10'd701, 10'd705, 10'd709, 10'd713, 10'd717, 10'd721, 10'd725, 10'd728, 10'd732, 10'd736,
    10'd740, 10'd744, 10'd748, 10'd752, 10'd756, 10'd760, 10'd764, 10'd768, 10'd772, 10'd775,
    10'd779, 10'd783, 10'd787, 10'd791, 10'd795, 10'd799, 10'd800, 10'd814, 10'd829, 10'd843,
    10'd857, 10'd871, 10'd886, 10'd900, 10'd914, 10'd929, 10'd943, 10'd957, 10'd971, 10'd986,
    10'd1000
  };

  // Percent to decipercent; anything above 100 reads the top entry.
  function automatic deci_t soc_remap(logic [6:0] soc);
    logic [6:0] idx;
    idx = (soc > 7'd100) ? 7'd100 : soc;
    return SOC_MAP[idx];
  endfunction

endpackage

// File: rtl/battery_status_frame_generator.sv
// Battery status frame generator top level: front end, frame queue, byte serializer.
// Depends on bsfg_pkg, bsfg_front, bsfg_fifo and bsfg_back.
//
//  Port group | Direction | Beat carries
//  in_*       | in        | one request: tuser = action, tdata = measurements
//  out_*      | out       | one frame byte, tlast on the checksum byte
//  cfg_*      | in        | one register write, no handshake
//
// A send beat becomes 12 output beats, one per cycle while out_tready is high; the serializer
// sets the sustained rate. A resync beat produces nothing. The front end builds a frame in
// the accept cycle; the first byte is valid once the serializer registers the head frame,
// when idle or as the prior checksum goes out. Input stalls only when QUEUE_DEPTH frames wait.
// Reset is synchronous and restores register defaults, slew state 0 and a 0x87 first frame.
module battery_status_frame_generator #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [6:0] soc_percent, [22:7] cell_v_high, [38:23] cell_v_low, [46:39] temp_c,
  // [54:47] pack_volts, [66:55] current_amps, [74:67] partner_byte_b3,
  // [82:75] partner_byte_b4, [87:83] zero
  input  logic [87:0] in_tdata,
  input  logic        in_tuser,   // [0] action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] frame_byte, [11:8] byte_index, [15:12] zero
  output logic        out_tlast   // last_byte
);
  import bsfg_pkg::*;

  frame_t push_frame, head_frame;
  logic   q_push, q_pop, q_full, q_valid;

  bsfg_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_frame   (push_frame)
  );

  bsfg_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .wr_frame  (push_frame),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .rd_frame  (head_frame)
  );

  bsfg_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_frame    (head_frame),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// File: rtl/bsfg_front.sv
// Front end: config registers, input beat decode, charge slew state, frame body build.
// Depends on bsfg_pkg; pushes finished frame bodies into bsfg_fifo.
module bsfg_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [15:0]      cfg_wdata,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [87:0]      in_tdata,
  input  logic             in_tuser,
  input  logic             q_full,
  output logic             q_push,
  output bsfg_pkg::frame_t q_frame
);
  import bsfg_pkg::*;

  logic [15:0] cell_v_max_r, cell_v_min_r;
  logic [6:0]  soc_max_r, soc_min_r;
  logic        reduce_regen_r;
  deci_t       prev_soc_r, prev_soc_nxt;
  logic        next_is_aa_r, next_is_aa_nxt;

  logic [6:0]  soc;
  logic [15:0] vhi, vlo;
  logic [7:0]  temp_raw, volts, b3, b4;
  logic [11:0] cur_raw;
  logic        fire, full, empty, no_engine;
  deci_t       target, d_slew, d_sent;
  logic signed [8:0] temp_sum;
  byte_t       temp_byte, flags, req;
  logic [13:0] amps14, counts;
  byte_t       cur_hi, cur_lo;

  assign soc      = in_tdata[6:0];
  assign vhi      = in_tdata[22:7];
  assign vlo      = in_tdata[38:23];
  assign temp_raw = in_tdata[46:39];
  assign volts    = in_tdata[54:47];
  assign cur_raw  = in_tdata[66:55];
  assign b3       = in_tdata[74:67];
  assign b4       = in_tdata[82:75];

  assign in_tready = !q_full;
  assign fire      = in_tvalid && in_tready;
  assign q_push    = fire && (in_tuser == ACTION_SEND);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_v_max_r   <= RST_CELL_V_MAX;
      cell_v_min_r   <= RST_CELL_V_MIN;
      soc_max_r      <= RST_SOC_MAX;
      soc_min_r      <= RST_SOC_MIN;
      reduce_regen_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_CELL_V_MAX_REGEN:  cell_v_max_r   <= cfg_wdata;
        REG_CELL_V_MIN_ASSIST: cell_v_min_r   <= cfg_wdata;
        REG_SOC_MAX_PERCENT:   soc_max_r      <= cfg_wdata[6:0];
        REG_SOC_MIN_PERCENT:   soc_min_r      <= cfg_wdata[6:0];
        REG_REDUCE_REGEN_MODE: reduce_regen_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    full   = (vhi >= cell_v_max_r) || (soc >= soc_max_r);
    empty  = (vlo <= cell_v_min_r) || (soc <= soc_min_r);
    target = full ? SOC_TGT_FULL : (empty ? SOC_TGT_EMPTY : soc_remap(soc));
    if (target > prev_soc_r)      d_slew = prev_soc_r + 10'd1;
    else if (target < prev_soc_r) d_slew = prev_soc_r - 10'd1;
    else                          d_slew = prev_soc_r;
    d_sent = (reduce_regen_r && d_slew < LIFT_LEVEL && d_slew > LIFT_FLOOR) ? LIFT_LEVEL
                                                                            : d_slew;

    temp_sum  = $signed({temp_raw[7], temp_raw}) + TEMP_OFFSET;
    temp_byte = (temp_sum < TEMP_MIN) ? byte_t'(TEMP_MIN) : temp_sum[7:0];

    // counts = 2048 - 20*amps, only 14 bits survive
    amps14 = {{2{cur_raw[11]}}, cur_raw};
    counts = CUR_OFFSET - ((amps14 << 4) + (amps14 << 2));
    cur_hi = {1'b0, counts[13:7]};
    cur_lo = {1'b0, counts[6:0]};

    no_engine = (b4 == B4_IDLE_A) || (b4 == B4_IDLE_B);
    flags = (empty ? FLAG_EMPTY : 8'h00) | (full ? FLAG_FULL : 8'h00);
    if (no_engine) req = empty ? REQ_EMPTY : REQ_FULL;
    else           req = REQ_BASE | (empty ? REQ_EMPTY : 8'h00) | (full ? REQ_FULL : 8'h00);
  end

  always_comb begin
    if (!next_is_aa_r) begin
      q_frame.body[0]  = FRAME_TYPE_87;
      q_frame.body[1]  = HDR_87;
      q_frame.body[2]  = {1'b0, volts[7:1]};
      q_frame.body[3]  = SOC_HI_MARK | {5'd0, d_sent[9:7]};
      q_frame.body[4]  = {1'b0, d_sent[6:0]};
      q_frame.body[5]  = cur_hi;
      q_frame.body[6]  = cur_lo;
      q_frame.body[7]  = FILL_87;
      q_frame.body[8]  = temp_byte;
      q_frame.body[9]  = temp_byte;
      q_frame.body[10] = b3;
    end else begin
      q_frame.body[0]  = FRAME_TYPE_AA;
      q_frame.body[1]  = HDR_AA;
      q_frame.body[2]  = 8'h00;
      q_frame.body[3]  = 8'h00;
      q_frame.body[4]  = 8'h00;
      q_frame.body[5]  = flags;
      q_frame.body[6]  = req;
      q_frame.body[7]  = FILL_AA;
      q_frame.body[8]  = cur_hi;
      q_frame.body[9]  = cur_lo;
      q_frame.body[10] = b4;
    end
  end

  always_comb begin
    prev_soc_nxt   = prev_soc_r;
    next_is_aa_nxt = next_is_aa_r;
    if (fire) begin
      if (in_tuser == ACTION_RESYNC) begin
        prev_soc_nxt = soc_remap(soc);
      end else begin
        if (!next_is_aa_r) prev_soc_nxt = d_slew;  // keeps the value before the lift
        next_is_aa_nxt = !next_is_aa_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_soc_r   <= '0;
      next_is_aa_r <= 1'b0;
    end else begin
      prev_soc_r   <= prev_soc_nxt;
      next_is_aa_r <= next_is_aa_nxt;
    end
  end

endmodule

// File: rtl/bsfg_fifo.sv
// Short frame queue between the front end and the byte serializer.
// Depends on bsfg_pkg for the frame record type.
`include "battery_status_frame_generator_defines.svh"
module bsfg_fifo #(
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  bsfg_pkg::frame_t wr_frame,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output bsfg_pkg::frame_t rd_frame
);
  import bsfg_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  frame_t          slot_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]   count_r;

  assign full      = (count_r == CW'(DEPTH));
  assign not_empty = (count_r != '0);
  assign rd_frame  = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= wr_frame;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      if (push && !pop)      count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

  `BSFG_ASSERT_NOW(a_no_overflow, push, !full, "frame pushed into full queue")
  `BSFG_ASSERT_NOW(a_no_underflow, pop, not_empty, "frame popped from empty queue")

endmodule

// File: rtl/bsfg_back.sv
// Back end: serializes one queued frame body per 12 beats and appends the checksum.
// Depends on bsfg_pkg; pulls frames from bsfg_fifo.
`include "battery_status_frame_generator_defines.svh"
module bsfg_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  bsfg_pkg::frame_t q_frame,
  output logic             q_pop,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [15:0]      out_tdata,
  output logic             out_tlast
);
  import bsfg_pkg::*;

  frame_t    frame_r;
  byte_idx_t idx_r;
  byte_t     sum_r;
  logic      active_r;
  logic      fire, last;
  byte_t     cur_byte;
  byte_t     neg_sum;

  assign last    = (idx_r == LAST_IDX);
  assign fire    = active_r && out_tready;
  assign neg_sum = 8'h00 - sum_r;
  assign cur_byte = last ? {1'b0, neg_sum[6:0]} : frame_r.body[idx_r];
  // next frame loads in the cycle its predecessor's checksum goes out
  assign q_pop   = q_valid && (!active_r || (fire && last));

  assign out_tvalid = active_r;
  assign out_tdata  = {4'h0, idx_r, cur_byte};
  assign out_tlast  = last;

  always_ff @(posedge clk) begin
    if (q_pop) frame_r <= q_frame;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      idx_r    <= '0;
      sum_r    <= '0;
    end else if (q_pop) begin
      active_r <= 1'b1;
      idx_r    <= '0;
      sum_r    <= '0;
    end else if (fire) begin
      if (last) begin
        active_r <= 1'b0;
      end else begin
        idx_r <= idx_r + 1'b1;
        sum_r <= sum_r + cur_byte;
      end
    end
  end

  `BSFG_ASSERT_NOW(a_idx_range, active_r, idx_r <= LAST_IDX, "byte index past checksum")
  `BSFG_ASSERT_NOW(a_checksum, active_r && last, ((sum_r + cur_byte) & 8'h7F) == 8'h00,
                   "checksum does not close frame")
  `BSFG_ASSERT_NEXT(a_drain, fire && last && !q_valid, !out_tvalid,
                    "output still valid after final beat")
  `BSFG_ASSERT_NEXT(a_hold, out_tvalid && !out_tready, out_tvalid && $stable(idx_r),
                    "stalled beat moved")

endmodule
